// ===== src/tpt_pkg.sv =====
`default_nettype none

package tpt_pkg;

    localparam int VA_WIDTH      = 16;
    localparam int OFFSET_BITS   = 8;
    localparam int PAGE_BITS     = 8;
    localparam int VIRTUAL_PAGES = 256;
    localparam int FRAME_BITS    = 7;
    localparam int FRAME_COUNT   = 128;
    localparam int PA_WIDTH      = 15;
    localparam int TLB_ENTRIES   = 16;
    localparam int TLB_IDX_BITS  = 4;
    localparam int CNT_WIDTH     = 32;

    typedef logic [PAGE_BITS-1:0]    page_t;
    typedef logic [FRAME_BITS-1:0]   frame_t;
    typedef logic [OFFSET_BITS-1:0]  offset_t;
    typedef logic [TLB_IDX_BITS-1:0] tlb_idx_t;
    typedef logic [CNT_WIDTH-1:0]    count_t;

    typedef struct packed {
        logic     hit;
        tlb_idx_t idx;
    } tlb_match_t;

endpackage

`default_nettype wire

// ===== src/tpt_ram.sv =====
`default_nettype none

module tpt_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 256,
    parameter int ADDR_BITS = $clog2(DEPTH)
) (
    input  wire logic                 clk,
    input  wire logic                 we,
    input  wire logic [ADDR_BITS-1:0] waddr,
    input  wire logic [WIDTH-1:0]     wdata,
    input  wire logic                 re,
    input  wire logic [ADDR_BITS-1:0] raddr,
    output logic      [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/tlb_paging_translator_unit.sv =====
`default_nettype none

// Demand-paging address translator. Each virtual address beat is split into a page and an
// offset; the page is matched against a 16-entry fully associative TLB, then the page map,
// and on a miss in both a frame is handed out in FIFO order, unmapping its previous owner.
// An address is accepted only when the translator is idle. The acceptance cycle reads the
// page-map and frame-owner RAMs; the lookup state then resolves the translation, registers
// the result and, on a page fault, writes both RAMs back. Because the RAM read is registered,
// no new address is taken until the current one is resolved; a full result register holds
// the translator in its lookup state. Validity of the page map and TLB lives in flip-flops
// cleared by reset, so no clearing pass is needed after reset.

module tlb_paging_translator_unit
    import tpt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                addr_valid,
    output logic                     addr_ready,
    input  wire logic [VA_WIDTH-1:0] virtual_address,
    output logic                     xlat_valid,
    input  wire logic                xlat_ready,
    output logic [PA_WIDTH-1:0]      physical_address,
    output logic                     tlb_hit,
    output logic                     page_fault,
    output logic                     evicted_valid,
    output logic [PAGE_BITS-1:0]     evicted_page,
    output logic [CNT_WIDTH-1:0]     hit_total,
    output logic [CNT_WIDTH-1:0]     fault_total
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_LOOKUP = 1'b1;

    localparam frame_t FRAME_LAST = FRAME_BITS'(FRAME_COUNT - 1);

    logic    state_reg;
    page_t   page_reg;
    offset_t offset_reg;
    frame_t  frame_ptr_reg;
    frame_t  frame_ptr_next;
    logic    wrapped_reg;
    count_t  hit_cnt_reg;
    count_t  hit_cnt_next;
    count_t  fault_cnt_reg;
    count_t  fault_cnt_next;
    tlb_idx_t tlb_ptr_reg;

    logic [VIRTUAL_PAGES-1:0] pm_valid_reg;
    logic [VIRTUAL_PAGES-1:0] pm_valid_next;
    logic [TLB_ENTRIES-1:0]   tlb_valid_reg;
    page_t                    tlb_tag_reg   [TLB_ENTRIES];
    frame_t                   tlb_frame_reg [TLB_ENTRIES];

    logic   xlat_valid_reg;
    logic [PA_WIDTH-1:0] pa_reg;
    logic   hit_out_reg;
    logic   fault_out_reg;
    logic   ev_valid_reg;
    page_t  ev_page_reg;
    count_t hit_total_reg;
    count_t fault_total_reg;

    logic       accept;
    logic       advance;
    frame_t     pm_rdata;
    page_t      fo_rdata;
    tlb_match_t page_match;
    tlb_match_t owner_match;
    logic       pm_hit;
    logic       fault;
    logic       evict;
    logic       tlb_push;
    logic       tlb_rename;
    frame_t     frame;
    frame_t     push_frame;

    function automatic tlb_match_t tlb_find(
        input logic [TLB_ENTRIES-1:0] valid,
        input page_t                  tags [TLB_ENTRIES],
        input page_t                  key
    );
        tlb_match_t m;
        m.hit = 1'b0;
        m.idx = '0;
        // scan downwards so the lowest matching entry wins
        for (int i = TLB_ENTRIES - 1; i >= 0; i--)
        begin
            if (valid[i] && tags[i] == key)
            begin
                m.hit = 1'b1;
                m.idx = TLB_IDX_BITS'(i);
            end
        end
        return m;
    endfunction

    assign addr_ready = (state_reg == ST_IDLE);
    assign accept     = addr_valid && addr_ready;
    assign advance    = (state_reg == ST_LOOKUP) && (!xlat_valid_reg || xlat_ready);

    tpt_ram #(
        .WIDTH (FRAME_BITS),
        .DEPTH (VIRTUAL_PAGES)
    ) u_page_map (
        .clk   (clk),
        .we    (advance && fault),
        .waddr (page_reg),
        .wdata (frame_ptr_reg),
        .re    (accept),
        .raddr (virtual_address[OFFSET_BITS +: PAGE_BITS]),
        .rdata (pm_rdata)
    );

    tpt_ram #(
        .WIDTH (PAGE_BITS),
        .DEPTH (FRAME_COUNT)
    ) u_frame_owner (
        .clk   (clk),
        .we    (advance && fault),
        .waddr (frame_ptr_reg),
        .wdata (page_reg),
        .re    (accept),
        .raddr (frame_ptr_reg),
        .rdata (fo_rdata)
    );

    always_comb
    begin
        page_match  = tlb_find(tlb_valid_reg, tlb_tag_reg, page_reg);
        owner_match = tlb_find(tlb_valid_reg, tlb_tag_reg, fo_rdata);
        pm_hit      = !page_match.hit && pm_valid_reg[page_reg];
        fault       = !page_match.hit && !pm_valid_reg[page_reg];
        // frame owner is valid once the FIFO has handed out every frame
        evict       = fault && wrapped_reg;
        tlb_push    = advance && (pm_hit || (evict && !owner_match.hit));
        tlb_rename  = advance && evict && owner_match.hit;
        priority if (page_match.hit)
        begin
            frame = tlb_frame_reg[page_match.idx];
        end
        else if (pm_hit)
        begin
            frame = pm_rdata;
        end
        else
        begin
            frame = frame_ptr_reg;
        end
        push_frame     = frame;
        frame_ptr_next = fault ? frame_ptr_reg + frame_t'(1) : frame_ptr_reg;
        hit_cnt_next   = (page_match.hit && hit_cnt_reg != '1)
                         ? hit_cnt_reg + count_t'(1) : hit_cnt_reg;
        fault_cnt_next = (fault && fault_cnt_reg != '1)
                         ? fault_cnt_reg + count_t'(1) : fault_cnt_reg;
        // unmap the old owner first; the new page is set after it
        pm_valid_next = pm_valid_reg;
        if (evict)
        begin
            pm_valid_next[fo_rdata] = 1'b0;
        end
        if (fault)
        begin
            pm_valid_next[page_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            frame_ptr_reg  <= '0;
            wrapped_reg    <= 1'b0;
            hit_cnt_reg    <= '0;
            fault_cnt_reg  <= '0;
            tlb_ptr_reg    <= '0;
            pm_valid_reg   <= '0;
            tlb_valid_reg  <= '0;
            xlat_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= ST_LOOKUP;
            end
            if (advance)
            begin
                state_reg      <= ST_IDLE;
                frame_ptr_reg  <= frame_ptr_next;
                hit_cnt_reg    <= hit_cnt_next;
                fault_cnt_reg  <= fault_cnt_next;
                xlat_valid_reg <= 1'b1;
                pm_valid_reg   <= pm_valid_next;
                if (fault && frame_ptr_reg == FRAME_LAST)
                begin
                    wrapped_reg <= 1'b1;
                end
            end
            else if (xlat_valid_reg && xlat_ready)
            begin
                xlat_valid_reg <= 1'b0;
            end
            if (tlb_push)
            begin
                tlb_valid_reg[tlb_ptr_reg] <= 1'b1;
                tlb_ptr_reg                <= tlb_ptr_reg + tlb_idx_t'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            page_reg   <= virtual_address[OFFSET_BITS +: PAGE_BITS];
            offset_reg <= virtual_address[OFFSET_BITS-1:0];
        end
        if (tlb_push)
        begin
            tlb_tag_reg[tlb_ptr_reg]   <= page_reg;
            tlb_frame_reg[tlb_ptr_reg] <= push_frame;
        end
        if (tlb_rename)
        begin
            tlb_tag_reg[owner_match.idx] <= page_reg;
        end
        if (advance)
        begin
            pa_reg          <= PA_WIDTH'({frame, offset_reg});
            hit_out_reg     <= page_match.hit;
            fault_out_reg   <= fault;
            ev_valid_reg    <= evict;
            ev_page_reg     <= evict ? fo_rdata : '0;
            hit_total_reg   <= hit_cnt_next;
            fault_total_reg <= fault_cnt_next;
        end
    end

    assign xlat_valid       = xlat_valid_reg;
    assign physical_address = pa_reg;
    assign tlb_hit          = hit_out_reg;
    assign page_fault       = fault_out_reg;
    assign evicted_valid    = ev_valid_reg;
    assign evicted_page     = ev_page_reg;
    assign hit_total        = hit_total_reg;
    assign fault_total      = fault_total_reg;

    a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(xlat_valid_reg) |-> $past(state_reg == ST_LOOKUP))
        else $error("result beat raised without a lookup");

    a_hit_fault_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        xlat_valid_reg |-> !(hit_out_reg && fault_out_reg))
        else $error("hit and fault flagged together");

    a_evict_needs_fault: assert property (@(posedge clk) disable iff (!rst_n)
        xlat_valid_reg && ev_valid_reg |-> fault_out_reg)
        else $error("eviction without a page fault");

    a_frame_ptr_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(frame_ptr_reg) |-> $past(advance && fault))
        else $error("frame pointer moved without a fault");

    a_single_tlb_update: assert property (@(posedge clk) disable iff (!rst_n)
        !(tlb_push && tlb_rename))
        else $error("TLB push and rename in the same cycle");

endmodule

`default_nettype wire

// ===== tb/tlb_translation_checker.sv =====
`timescale 1ns / 100ps

module tlb_translation_checker
    import tpt_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                addr_valid,
    input  wire logic                addr_ready,
    input  wire logic [VA_WIDTH-1:0] virtual_address,
    input  wire logic                xlat_valid,
    input  wire logic                xlat_ready,
    input  wire logic [PA_WIDTH-1:0] physical_address,
    input  wire logic                tlb_hit,
    input  wire logic                page_fault,
    input  wire logic                evicted_valid,
    input  wire page_t               evicted_page,
    input  wire count_t              hit_total,
    input  wire count_t              fault_total,
    output int unsigned              mismatches,
    output int unsigned              outstanding,
    output int unsigned              translated,
    output int unsigned              hits_seen,
    output int unsigned              faults_seen,
    output int unsigned              evictions_seen
);

    typedef struct packed {
        logic [PA_WIDTH-1:0] physical_address;
        logic                tlb_hit;
        logic                page_fault;
        logic                evicted_valid;
        page_t               evicted_page;
        count_t              hit_total;
        count_t              fault_total;
    } xlat_t;

    logic     map_valid   [VIRTUAL_PAGES];
    frame_t   map_frame   [VIRTUAL_PAGES];
    logic     owner_valid [FRAME_COUNT];
    page_t    owner_page  [FRAME_COUNT];
    logic     tlb_valid   [TLB_ENTRIES];
    page_t    tlb_page    [TLB_ENTRIES];
    frame_t   tlb_frame   [TLB_ENTRIES];
    tlb_idx_t tlb_next;
    frame_t   frame_next;
    count_t   hit_count;
    count_t   fault_count;
    xlat_t    expected_xlat [$];

    // lowest matching entry wins
    function automatic int tlb_lookup(input page_t pg);
        for (int i = 0; i < TLB_ENTRIES; i++)
            if (tlb_valid[i] && tlb_page[i] == pg)
                return i;
        return -1;
    endfunction

    function automatic void tlb_insert(input page_t pg, input frame_t fr);
        tlb_valid[tlb_next] = 1'b1;
        tlb_page[tlb_next]  = pg;
        tlb_frame[tlb_next] = fr;
        tlb_next            = tlb_next + 1'b1;
    endfunction

    function automatic xlat_t translate_address(input logic [VA_WIDTH-1:0] va);
        xlat_t  res;
        page_t  pg;
        page_t  old;
        frame_t fr;
        int     slot;
        res  = '0;
        pg   = va[VA_WIDTH-1 -: PAGE_BITS];
        slot = tlb_lookup(pg);
        if (slot >= 0)
        begin
            res.tlb_hit = 1'b1;
            fr          = tlb_frame[slot];
            if (hit_count != '1)
                hit_count++;
        end
        else if (map_valid[pg])
        begin
            fr = map_frame[pg];
            tlb_insert(pg, fr);
        end
        else
        begin
            res.page_fault = 1'b1;
            if (fault_count != '1)
                fault_count++;
            fr = frame_next;
            if (owner_valid[fr])
            begin
                // unmap the old owner; rename its TLB entry if it has one
                old               = owner_page[fr];
                res.evicted_valid = 1'b1;
                res.evicted_page  = old;
                map_valid[old]    = 1'b0;
                slot              = tlb_lookup(old);
                if (slot >= 0)
                    tlb_page[slot] = pg;
                else
                    tlb_insert(pg, fr);
            end
            map_valid[pg]   = 1'b1;
            map_frame[pg]   = fr;
            owner_valid[fr] = 1'b1;
            owner_page[fr]  = pg;
            frame_next      = fr + 1'b1;
        end
        res.physical_address = {fr, va[OFFSET_BITS-1:0]};
        res.hit_total        = hit_count;
        res.fault_total      = fault_count;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        xlat_t got;
        xlat_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < VIRTUAL_PAGES; i++)
            begin
                map_valid[i] = 1'b0;
                map_frame[i] = '0;
            end
            for (int i = 0; i < FRAME_COUNT; i++)
            begin
                owner_valid[i] = 1'b0;
                owner_page[i]  = '0;
            end
            for (int i = 0; i < TLB_ENTRIES; i++)
            begin
                tlb_valid[i] = 1'b0;
                tlb_page[i]  = '0;
                tlb_frame[i] = '0;
            end
            tlb_next       = '0;
            frame_next     = '0;
            hit_count      = '0;
            fault_count    = '0;
            expected_xlat.delete();
            mismatches     = 0;
            outstanding    = 0;
            translated     = 0;
            hits_seen      = 0;
            faults_seen    = 0;
            evictions_seen = 0;
        end
        else
        begin
            // retire the result beat before predicting a new address beat
            if (xlat_valid && xlat_ready)
            begin
                got = '{physical_address, tlb_hit, page_fault, evicted_valid,
                        evicted_page, hit_total, fault_total};
                if (expected_xlat.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result beat with nothing outstanding, pa=%h",
                                 $realtime, physical_address);
                end
                else
                begin
                    want = expected_xlat.pop_front();
                    translated++;
                    if (got !== want)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: result %0d differs\n",
                                      "  exp pa=%h hit=%b fault=%b ev=%b/%h hits=%0d faults=%0d\n",
                                      "  got pa=%h hit=%b fault=%b ev=%b/%h hits=%0d faults=%0d"},
                                     $realtime, translated,
                                     want.physical_address, want.tlb_hit, want.page_fault,
                                     want.evicted_valid, want.evicted_page, want.hit_total,
                                     want.fault_total,
                                     got.physical_address, got.tlb_hit, got.page_fault,
                                     got.evicted_valid, got.evicted_page, got.hit_total,
                                     got.fault_total);
                    end
                end
            end
            if (addr_valid && addr_ready)
            begin
                want = translate_address(virtual_address);
                hits_seen      += want.tlb_hit;
                faults_seen    += want.page_fault;
                evictions_seen += want.evicted_valid;
                expected_xlat.push_back(want);
            end
            outstanding = expected_xlat.size();
        end
    end

endmodule

// ===== tb/tlb_paging_translator_unit_test.sv =====
`timescale 1ns / 100ps

module tlb_paging_translator_unit_test;
    import tpt_pkg::*;

    localparam int ADDRESS_COUNT = 1400;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 200000;

    logic                clk;
    logic                rst_n;
    logic                addr_valid;
    logic                addr_ready;
    logic [VA_WIDTH-1:0] virtual_address;
    logic                xlat_valid;
    logic                xlat_ready;
    logic [PA_WIDTH-1:0] physical_address;
    logic                tlb_hit;
    logic                page_fault;
    logic                evicted_valid;
    page_t               evicted_page;
    count_t              hit_total;
    count_t              fault_total;

    int unsigned mismatches;
    int unsigned outstanding;
    int unsigned translated;
    int unsigned hits_seen;
    int unsigned faults_seen;
    int unsigned evictions_seen;
    int unsigned accepted_addrs;
    int unsigned cycles;
    logic        hold_off;

    tlb_paging_translator_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .addr_valid       (addr_valid),
        .addr_ready       (addr_ready),
        .virtual_address  (virtual_address),
        .xlat_valid       (xlat_valid),
        .xlat_ready       (xlat_ready),
        .physical_address (physical_address),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .evicted_valid    (evicted_valid),
        .evicted_page     (evicted_page),
        .hit_total        (hit_total),
        .fault_total      (fault_total)
    );

    tlb_translation_checker checker_i (
        .clk              (clk),
        .rst_n            (rst_n),
        .addr_valid       (addr_valid),
        .addr_ready       (addr_ready),
        .virtual_address  (virtual_address),
        .xlat_valid       (xlat_valid),
        .xlat_ready       (xlat_ready),
        .physical_address (physical_address),
        .tlb_hit          (tlb_hit),
        .page_fault       (page_fault),
        .evicted_valid    (evicted_valid),
        .evicted_page     (evicted_page),
        .hit_total        (hit_total),
        .fault_total      (fault_total),
        .mismatches       (mismatches),
        .outstanding      (outstanding),
        .translated       (translated),
        .hits_seen        (hits_seen),
        .faults_seen      (faults_seen),
        .evictions_seen   (evictions_seen)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic send_address(input logic [VA_WIDTH-1:0] va);
        int unsigned gap;
        // every third stretch of 50 beats runs back to back
        gap = (accepted_addrs % 150 < 50) ? 0 : $urandom_range(0, 9);
        if (gap != 0)
        begin
            addr_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        addr_valid      <= 1'b1;
        virtual_address <= va;
        do @(posedge clk); while (!addr_ready);
        accepted_addrs++;
    endtask

    // receiver: hold ready low for a drawn number of cycles after each beat, except for the last 50 of every 150 beats
    initial
    begin
        int unsigned gap;
        int unsigned taken;
        xlat_ready = 1'b0;
        gap        = 0;
        taken      = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (xlat_valid && xlat_ready)
            begin
                taken++;
                gap = (taken % 150 >= 100) ? 0 : $urandom_range(0, 9);
            end
            else if (gap != 0)
                gap--;
            xlat_ready <= (gap == 0) && !hold_off;
        end
    end

    // one long output stall so the translator backs up onto its input
    initial
    begin
        hold_off = 1'b0;
        wait (accepted_addrs >= 500);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin
        logic [VA_WIDTH-1:0] directed [15];
        page_t       working_set [24];
        page_t       pg;
        int unsigned pick;

        directed = '{
            16'h0000, 16'h00FF, 16'h0012, 16'hFFFF, 16'hFF00, 16'hFF80,
            16'h8001, 16'h7FFE, 16'h5555, 16'hAAAA, 16'h0180, 16'h8001,
            16'h8002, 16'h7F00, 16'h00FF
        };
        cycles          = 0;
        accepted_addrs  = 0;
        rst_n           = 1'b0;
        addr_valid      = 1'b0;
        virtual_address = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_address(directed[i]);

        foreach (working_set[i])
            working_set[i] = page_t'($urandom);

        // mostly a drifting working set: a hot core that stays in the TLB, a wider ring
        // that thrashes it, and stray pages that use up frames and force evictions
        for (int n = 0; n < ADDRESS_COUNT; n++)
        begin
            if ($urandom_range(0, 7) == 0)
                working_set[$urandom_range(0, 23)] = page_t'($urandom);
            pick = $urandom_range(0, 9);
            if (pick < 5)
                pg = working_set[$urandom_range(0, 7)];
            else if (pick < 8)
                pg = working_set[$urandom_range(0, 23)];
            else
                pg = page_t'($urandom);
            send_address({pg, offset_t'($urandom)});
        end
        addr_valid <= 1'b0;

        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Translated %0d of %0d addresses: %0d TLB hits, %0d page faults, %0d evictions",
                 translated, accepted_addrs, hits_seen, faults_seen, evictions_seen);
        $display("Random idling on both channels plus one %0d-cycle output stall",
                 HOLD_CYCLES);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
